/* rtl/arl_pkg.sv */
// ----------------------------------------------------------------------------
// arl_pkg
// shared types and constants of the area-averaging line resampler
// ----------------------------------------------------------------------------
package arl_pkg;

  localparam int PIX_W     = 8;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;
  localparam int QUOT_W    = 9;
  localparam int NUM_CH    = 3;
  localparam int CH_W      = 2;

  localparam logic [CFG_IDX_W-1:0] REG_IN_LENGTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LENGTH = 1'b1;

  localparam logic [PIX_W-1:0] PIX_MAX = {PIX_W{1'b1}};

  typedef struct packed {
    logic [PIX_W-1:0] red_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] red_out;
    logic [PIX_W-1:0] green_out;
    logic [PIX_W-1:0] blue_out;
    logic             line_last;
  } out_item_t;

endpackage

/* rtl/arl_div.sv */
// ----------------------------------------------------------------------------
// arl_div
// restoring divider, one quotient bit per cycle, computes num / (2 * den)
// ----------------------------------------------------------------------------
module arl_div #(
  parameter int LEN_W = 13
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [LEN_W+arl_pkg::QUOT_W-1:0] num_i,
  input  logic [LEN_W-1:0]               den_i,
  output logic                           done_o,
  output logic [arl_pkg::QUOT_W-1:0]     quot_o
);

  localparam int DW    = LEN_W + arl_pkg::QUOT_W;
  localparam int CNT_W = $clog2(arl_pkg::QUOT_W);

  logic                       busy_q;
  logic                       done_q;
  logic [CNT_W-1:0]           cnt_q;
  logic [DW-1:0]              rem_q;
  logic [DW-1:0]              dsh_q;
  logic [arl_pkg::QUOT_W-1:0] quot_q;
  logic                       fits;

  assign fits = (rem_q >= dsh_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CNT_W'(arl_pkg::QUOT_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + CNT_W'(1);
        end
      end
    end
  end

  // divisor starts at (2 * den) shifted up by the top quotient bit
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= num_i;
      dsh_q  <= {den_i, {arl_pkg::QUOT_W{1'b0}}};
      quot_q <= '0;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= rem_q - dsh_q;
      end
      dsh_q  <= dsh_q >> 1;
      quot_q <= {quot_q[arl_pkg::QUOT_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && !busy_q)
    else $error("divider done without a finished run");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("divider done held longer than one cycle");

endmodule

/* rtl/area_resample_line.sv */
// ----------------------------------------------------------------------------
// area_resample_line
// one-dimensional area-averaging resampler for lines of rgb pixels
// ----------------------------------------------------------------------------
// usage
//   in channel (in_valid_i / in_ready_o / in_data_i): one source pixel per
//   transaction. out channel (out_valid_o / out_ready_i / out_data_o): one
//   resampled pixel per transaction, line_last set on the final pixel of a line.
//   cfg port: cfg_we_i writes in_length (index 0) or out_length (index 1);
//   any write restarts the line. write only while the block is idle.
// operation
//   a source pixel that closes no output passes through one accumulate step
//   only. each output it closes adds three channel divisions, run one after
//   another on one shared restoring divider (one quotient bit per cycle), and
//   a load of the output register; if source share is left, another accumulate
//   step follows. in_ready_o is low while a pixel is being worked on.
// reset and stall
//   after reset both lengths are 1 and the line is empty. a finished pixel
//   waits in the output register; work goes on until the next pixel must be
//   loaded there, and that step waits while out_valid_o is high and
//   out_ready_i is low.
// ----------------------------------------------------------------------------
module area_resample_line #(
  parameter int MAX_LEN     = 4096,
  parameter int MAX_UPSCALE = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [arl_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [arl_pkg::CFG_W-1:0]       cfg_data_i,
  input  arl_pkg::in_item_t               in_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  output arl_pkg::out_item_t              out_data_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i
);

  localparam int LW  = $clog2(MAX_LEN + 1);
  localparam int SW  = $clog2((2 ** arl_pkg::PIX_W - 1) * MAX_LEN + 1);
  localparam int DW  = LW + arl_pkg::QUOT_W;
  localparam int UW  = $clog2(MAX_UPSCALE + 1);
  localparam int EW  = (LW + UW > arl_pkg::CFG_W) ? LW + UW : arl_pkg::CFG_W;
  localparam int PW  = arl_pkg::PIX_W;
  localparam int CHW = arl_pkg::CH_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_EMIT
  } state_e;

  state_e                     state_q, state_d;
  logic [arl_pkg::CFG_W-1:0]  in_len_q, in_len_d;
  logic [arl_pkg::CFG_W-1:0]  out_len_q, out_len_d;
  logic [LW-1:0]              src_q, src_d;
  logic [LW-1:0]              tgt_q, tgt_d;
  logic [LW-1:0]              cnt_q, cnt_d;
  logic [SW-1:0]              sum_q [arl_pkg::NUM_CH];
  logic [SW-1:0]              sum_d [arl_pkg::NUM_CH];
  logic [CHW-1:0]             ch_q, ch_d;
  logic                       out_valid_q, out_valid_d;
  logic [PW-1:0]              px_q [arl_pkg::NUM_CH];
  logic [PW-1:0]              px_d [arl_pkg::NUM_CH];
  logic [PW-1:0]              quot_q [arl_pkg::NUM_CH];
  logic [PW-1:0]              quot_d [arl_pkg::NUM_CH];
  arl_pkg::out_item_t         out_data_q, out_data_d;

  logic [EW-1:0]              in_ext, out_ext, up_lim;
  logic [LW-1:0]              li, lo;
  logic [LW-1:0]              take, src_rem, tgt_rem, cnt_inc;
  logic                       last, out_free;
  logic                       div_start, div_done;
  logic [DW-1:0]              div_num;
  logic [arl_pkg::QUOT_W-1:0] div_quot;

  // effective lengths: zero acts as one, saturate at MAX_LEN, limit upscale
  always_comb begin
    in_ext = EW'(in_len_q);
    if (in_ext == '0) begin
      in_ext = EW'(1);
    end else if (in_ext > EW'(MAX_LEN)) begin
      in_ext = EW'(MAX_LEN);
    end
    up_lim  = EW'(EW'(MAX_UPSCALE) * in_ext);
    out_ext = EW'(out_len_q);
    if (out_ext == '0) begin
      out_ext = EW'(1);
    end else if (out_ext > EW'(MAX_LEN)) begin
      out_ext = EW'(MAX_LEN);
    end
    if (out_ext > up_lim) begin
      out_ext = up_lim;
    end
  end

  assign li = LW'(in_ext);
  assign lo = LW'(out_ext);

  assign take     = (src_q < tgt_q) ? src_q : tgt_q;
  assign src_rem  = src_q - take;
  assign tgt_rem  = tgt_q - take;
  assign cnt_inc  = cnt_q + LW'(1);
  assign last     = (cnt_inc >= lo);
  assign out_free = !out_valid_q || out_ready_i;
  assign div_num  = DW'({sum_q[ch_q], 1'b0}) + DW'(li);

  arl_div #(
    .LEN_W (LW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (li),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_comb begin
    state_d     = state_q;
    in_len_d    = in_len_q;
    out_len_d   = out_len_q;
    src_d       = src_q;
    tgt_d       = tgt_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    ch_d        = ch_q;
    px_d        = px_q;
    quot_d      = quot_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !out_ready_i;
    div_start   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          px_d[0] = in_data_i.red_in;
          px_d[1] = in_data_i.green_in;
          px_d[2] = in_data_i.blue_in;
          src_d   = lo;
          if (tgt_q == '0 || tgt_q > li) begin
            tgt_d = li;
          end
          state_d = ST_STEP;
        end
      end
      ST_STEP: begin
        for (int c = 0; c < arl_pkg::NUM_CH; c++) begin
          sum_d[c] = SW'(sum_q[c] + SW'(px_q[c]) * SW'(take));
        end
        src_d = src_rem;
        tgt_d = tgt_rem;
        if (tgt_rem == '0) begin
          ch_d    = '0;
          state_d = ST_DIV_START;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DIV_START: begin
        div_start = 1'b1;
        state_d   = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          quot_d[ch_q] = div_quot[arl_pkg::QUOT_W-1] ? arl_pkg::PIX_MAX
                                                     : div_quot[PW-1:0];
          if (ch_q == CHW'(arl_pkg::NUM_CH - 1)) begin
            state_d = ST_EMIT;
          end else begin
            ch_d    = ch_q + CHW'(1);
            state_d = ST_DIV_START;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_data_d.red_out   = quot_q[0];
          out_data_d.green_out = quot_q[1];
          out_data_d.blue_out  = quot_q[2];
          out_data_d.line_last = last;
          out_valid_d          = 1'b1;
          for (int c = 0; c < arl_pkg::NUM_CH; c++) begin
            sum_d[c] = '0;
          end
          tgt_d = li;
          if (last) begin
            cnt_d   = '0;
            src_d   = '0;
            state_d = ST_IDLE;
          end else begin
            cnt_d   = cnt_inc;
            state_d = (src_q == '0) ? ST_IDLE : ST_STEP;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // register write restarts the line; target share reloads on next pixel
    if (cfg_we_i) begin
      case (cfg_idx_i)
        arl_pkg::REG_IN_LENGTH: begin
          in_len_d = cfg_data_i;
        end
        arl_pkg::REG_OUT_LENGTH: begin
          out_len_d = cfg_data_i;
        end
        default: begin
        end
      endcase
      tgt_d = '0;
      cnt_d = '0;
      for (int c = 0; c < arl_pkg::NUM_CH; c++) begin
        sum_d[c] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_len_q    <= arl_pkg::CFG_W'(1);
      out_len_q   <= arl_pkg::CFG_W'(1);
      src_q       <= '0;
      tgt_q       <= '0;
      cnt_q       <= '0;
      ch_q        <= '0;
      out_valid_q <= 1'b0;
      for (int c = 0; c < arl_pkg::NUM_CH; c++) begin
        sum_q[c] <= '0;
      end
    end else begin
      state_q     <= state_d;
      in_len_q    <= in_len_d;
      out_len_q   <= out_len_d;
      src_q       <= src_d;
      tgt_q       <= tgt_d;
      cnt_q       <= cnt_d;
      ch_q        <= ch_d;
      out_valid_q <= out_valid_d;
      sum_q       <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q       <= px_d;
    quot_q     <= quot_d;
    out_data_q <= out_data_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a pixel is in work");

  a_step_share: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP) |-> (tgt_q != '0) && (tgt_q <= li))
    else $error("target share out of range in accumulate step");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < lo)
    else $error("output count reached line length");

  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV_WAIT))
    else $error("division finished outside wait state");

  a_emit_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_EMIT))
    else $error("output loaded outside emit state");

endmodule
